### sv/tdc_pkg.sv
// Shared types and constants of the telegram dispatch connection block.
// Holds the request and result item structs, action and reply codes and
// the transport and command byte codes. No dependencies.
package tdc_pkg;

    typedef enum logic [3:0] {
        ACT_NONE        = 4'd0,
        ACT_SET_PA      = 4'd1,
        ACT_READ_PA     = 4'd2,
        ACT_MEM_WRITE   = 4'd3,
        ACT_MEM_READ    = 4'd4,
        ACT_RESTART     = 4'd5,
        ACT_READ_MASK   = 4'd6,
        ACT_CONNECT     = 4'd7,
        ACT_DISCONNECT  = 4'd8,
        ACT_PEER_ACK    = 4'd9,
        ACT_GROUP_WRITE = 4'd10,
        ACT_GROUP_READ  = 4'd11,
        ACT_CAPTURED    = 4'd12
    } t_action;

    typedef enum logic [1:0] {
        RPL_NONE = 2'd0,
        RPL_ACK  = 2'd1,
        RPL_NACK = 2'd2
    } t_reply;

    typedef enum logic [1:0] {
        REG_OWN_ADDR    = 2'd0,
        REG_PROG_MODE   = 2'd1,
        REG_TRANSPARENT = 2'd2
    } t_reg_idx;

    localparam logic [7:0] TPCI_MASK       = 8'hC3;
    localparam logic [7:0] TPCI_UDP        = 8'h00;
    localparam logic [7:0] TPCI_BCAST_READ = 8'h01;
    localparam logic [7:0] TPCI_NDP        = 8'h42;
    localparam logic [7:0] TPCI_NDP_CTRL   = 8'h43;
    localparam logic [7:0] TPCI_CONNECT    = 8'h80;
    localparam logic [7:0] TPCI_DISCONNECT = 8'h81;
    localparam logic [7:0] TPCI_ACK        = 8'hC2;
    localparam logic [7:0] TPCI_NAK        = 8'hC3;

    localparam logic [7:0] APCI_CLASS_MASK = 8'hC0;
    localparam logic [7:0] APCI_WRITE      = 8'h80;
    localparam logic [7:0] APCI_READ       = 8'h00;
    localparam logic [7:0] APCI_SET_PA     = 8'hC0;
    localparam logic [7:0] APCI_RESTART    = 8'h80;

    localparam logic [3:0] SEQ_START = 4'd1;

    typedef struct packed {
        logic        checksum_ok;
        logic [4:0]  byte_count;
        logic [15:0] source_address;
        logic [15:0] dest_address;
        logic        group_flag;
        logic [7:0]  tpci_byte;
        logic [7:0]  apci_byte;
    } t_req;

    typedef struct packed {
        t_action     action;
        t_reply      reply;
        logic        send_transport_ack;
        logic [3:0]  response_sequence;
        logic        link_connected;
        logic [15:0] peer_address;
    } t_rsp;

endpackage

### sv/tdc_req_if.sv
// Request channel of the telegram dispatch connection block.
// Carries one received telegram header per request. Depends on tdc_pkg.
interface tdc_req_if;
    import tdc_pkg::*;

    logic valid;
    logic ready;
    t_req item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

### sv/tdc_rsp_if.sv
// Result channel of the telegram dispatch connection block.
// Carries one dispatch decision per request. Depends on tdc_pkg.
interface tdc_rsp_if;
    import tdc_pkg::*;

    logic valid;
    logic ready;
    t_rsp item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

### sv/telegram_dispatch_connection.sv
// Top level of the telegram dispatch connection block: input register,
// header decode, connection state and result register with APB registers.
// Depends on tdc_pkg, tdc_req_if and tdc_rsp_if.
//
//   Channel   Direction  Handshake            Contents
//   i_req     in         valid/ready          received telegram header
//   o_rsp     out        valid/ready          action, reply, link state
//   APB       in/out     psel/penable/pready  own address, mode bits
//
// A request passes through the input register and then the result register.
// One request is accepted per cycle unless the input register stalls.
// The input register stalls only while the result register holds a result
// that is not taken. Reset is synchronous and clears all control state.
module telegram_dispatch_connection (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tdc_req_if.sink       i_req,
    tdc_rsp_if.source     o_rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import tdc_pkg::*;

    logic        r_in_valid;
    t_req        r_in;
    logic        r_out_valid;
    t_rsp        r_out;

    logic [15:0] r_own_address;
    logic        r_prog_mode;
    logic        r_transparent_mode;
    logic        r_connected;
    logic [15:0] r_partner_address;
    logic [3:0]  r_sequence_counter;
    logic [4:0]  r_captured_length;

    logic        n_prog_mode;
    logic        n_transparent_mode;
    logic        n_connected;
    logic [15:0] n_partner_address;
    logic [3:0]  n_sequence_counter;
    logic [4:0]  n_captured_length;
    t_rsp        n_out;

    logic        w_adv;
    logic        w_cfg_wr;
    t_reg_idx    w_reg_idx;
    logic [7:0]  w_tpci;
    logic [7:0]  w_apci;

    assign w_adv       = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_adv;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.item  = r_out;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = t_reg_idx'(paddr[3:2]);

    always_comb begin
        unique case (w_reg_idx)
            REG_OWN_ADDR:    prdata = {16'd0, r_own_address};
            REG_PROG_MODE:   prdata = {31'd0, r_prog_mode};
            REG_TRANSPARENT: prdata = {19'd0, r_captured_length, 7'd0, r_transparent_mode};
            default:         prdata = 32'd0;
        endcase
    end

    assign w_tpci = r_in.tpci_byte & TPCI_MASK;
    assign w_apci = r_in.apci_byte;

    always_comb begin
        n_prog_mode        = r_prog_mode;
        n_transparent_mode = r_transparent_mode;
        n_connected        = r_connected;
        n_partner_address  = r_partner_address;
        n_sequence_counter = r_sequence_counter;
        n_captured_length  = r_captured_length;
        n_out              = '0;
        n_out.action       = ACT_NONE;
        n_out.reply        = RPL_NONE;

        if (!r_in.checksum_ok) begin
            if (r_in.byte_count > 5'd1) begin
                n_out.reply = RPL_NACK;
            end
        end else if (r_transparent_mode) begin
            n_captured_length = r_in.byte_count;
            n_out.action      = ACT_CAPTURED;
        end else if (r_in.dest_address == 16'd0) begin
            if (r_prog_mode) begin
                if (w_tpci == TPCI_UDP && w_apci == APCI_SET_PA) begin
                    n_out.action = ACT_SET_PA;
                end else if (w_tpci == TPCI_BCAST_READ && w_apci == APCI_READ) begin
                    n_out.action = ACT_READ_PA;
                    n_out.reply  = RPL_ACK;
                end
            end
        end else if (!r_in.group_flag) begin
            if (r_in.dest_address == r_own_address) begin
                unique case (w_tpci) inside
                    TPCI_NDP: begin
                        if ((w_apci & APCI_CLASS_MASK) == APCI_WRITE) begin
                            n_out.action             = ACT_MEM_WRITE;
                            n_out.reply              = RPL_ACK;
                            n_out.send_transport_ack = 1'b1;
                        end else if ((w_apci & APCI_CLASS_MASK) == APCI_READ) begin
                            n_out.action             = ACT_MEM_READ;
                            n_out.reply              = RPL_ACK;
                            n_out.send_transport_ack = 1'b1;
                            n_out.response_sequence  = r_sequence_counter;
                            n_sequence_counter       = r_sequence_counter + 4'd1;
                        end
                    end
                    TPCI_NDP_CTRL: begin
                        if (w_apci == APCI_RESTART) begin
                            n_out.action       = ACT_RESTART;
                            n_prog_mode        = 1'b0;
                            n_transparent_mode = 1'b0;
                            n_captured_length  = 5'd0;
                            n_connected        = 1'b0;
                            n_sequence_counter = SEQ_START;
                        end else if (w_apci == APCI_READ) begin
                            n_out.action             = ACT_READ_MASK;
                            n_out.reply              = RPL_ACK;
                            n_out.send_transport_ack = 1'b1;
                        end
                    end
                    TPCI_CONNECT: begin
                        if (!r_connected) begin
                            n_out.action       = ACT_CONNECT;
                            n_out.reply        = RPL_ACK;
                            n_connected        = 1'b1;
                            n_partner_address  = r_in.source_address;
                            n_sequence_counter = SEQ_START;
                        end
                    end
                    TPCI_DISCONNECT: begin
                        if (r_connected && r_partner_address == r_in.source_address) begin
                            n_out.action       = ACT_DISCONNECT;
                            n_connected        = 1'b0;
                            n_sequence_counter = SEQ_START;
                        end
                    end
                    TPCI_ACK, TPCI_NAK: begin
                        n_out.action = ACT_PEER_ACK;
                        n_out.reply  = RPL_ACK;
                    end
                    default: begin
                        n_out.action = ACT_NONE;
                    end
                endcase
            end
        end else begin
            if (w_tpci == TPCI_UDP) begin
                if ((w_apci & APCI_CLASS_MASK) == APCI_WRITE) begin
                    n_out.action = ACT_GROUP_WRITE;
                end else if (w_apci == APCI_READ) begin
                    n_out.action = ACT_GROUP_READ;
                end
            end
        end

        n_out.link_connected = n_connected;
        n_out.peer_address   = n_partner_address;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.item;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address      <= 16'd0;
            r_prog_mode        <= 1'b0;
            r_transparent_mode <= 1'b0;
            r_connected        <= 1'b0;
            r_partner_address  <= 16'd0;
            r_sequence_counter <= SEQ_START;
            r_captured_length  <= 5'd0;
        end else if (w_adv) begin
            r_prog_mode        <= n_prog_mode;
            r_transparent_mode <= n_transparent_mode;
            r_connected        <= n_connected;
            r_partner_address  <= n_partner_address;
            r_sequence_counter <= n_sequence_counter;
            r_captured_length  <= n_captured_length;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_OWN_ADDR:    r_own_address      <= pwdata[15:0];
                REG_PROG_MODE:   r_prog_mode        <= pwdata[0];
                REG_TRANSPARENT: r_transparent_mode <= pwdata[0];
                default:         r_own_address      <= r_own_address;
            endcase
        end
    end

    a_seq_only_mem_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.action != ACT_MEM_READ |-> r_out.response_sequence == 4'd0)
        else $error("response sequence set on an action other than memory read");

    a_tack_needs_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.send_transport_ack |-> r_out.reply == RPL_ACK)
        else $error("transport acknowledge without an immediate acknowledge");

    a_ack_has_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.reply == RPL_ACK |-> r_out.action != ACT_NONE)
        else $error("acknowledge given for a dropped telegram");

    a_seq_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && n_out.action == ACT_MEM_READ
        |=> r_sequence_counter == $past(r_sequence_counter) + 4'd1)
        else $error("packet counter did not advance after a memory read");

    a_link_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out.link_connected == r_connected
                  && r_out.peer_address == r_partner_address)
        else $error("reported link state differs from the connection state");

endmodule

### verif/telegram_dispatch_connection_test.sv
// Self-checking testbench of the telegram dispatch connection block.
// Drives telegram headers and APB register writes, predicts every dispatch decision
// and checks each result in order. Depends on tdc_pkg, tdc_req_if and tdc_rsp_if.
`timescale 1ns / 100ps

module telegram_dispatch_connection_test;
    import tdc_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tdc_req_if req_if ();
    tdc_rsp_if rsp_if ();

    telegram_dispatch_connection dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Mirror of the block's configuration registers and connection state.
    logic [15:0] own_addr_cfg;
    logic        prog_cfg;
    logic        transparent_cfg;
    logic        link_up;
    logic [15:0] partner_addr;
    logic [3:0]  packet_count;

    t_rsp expected_dispatch [$];
    int unsigned mismatch_count;
    int unsigned reported_count;
    int unsigned send_gap_max;
    int unsigned recv_stall_max;
    int unsigned receiver_hold;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic t_req telegram(input logic ck, input logic [4:0] cnt,
                                      input logic [15:0] src, input logic [15:0] dst,
                                      input logic grp, input logic [7:0] tp,
                                      input logic [7:0] ap);
        t_req r;
        r.checksum_ok    = ck;
        r.byte_count     = cnt;
        r.source_address = src;
        r.dest_address   = dst;
        r.group_flag     = grp;
        r.tpci_byte      = tp;
        r.apci_byte      = ap;
        return r;
    endfunction

    function automatic t_rsp predict_dispatch(input t_req r);
        t_rsp res;
        logic [7:0] tp;
        logic [7:0] ap;
        tp = r.tpci_byte & TPCI_MASK;
        ap = r.apci_byte;
        res.action             = ACT_NONE;
        res.reply              = RPL_NONE;
        res.send_transport_ack = 1'b0;
        res.response_sequence  = 4'd0;
        if (!r.checksum_ok) begin
            if (r.byte_count > 5'd1) res.reply = RPL_NACK;
        end else if (transparent_cfg) begin
            res.action = ACT_CAPTURED;
        end else if (r.dest_address == 16'h0000) begin
            if (prog_cfg) begin
                if (tp == TPCI_UDP && ap == APCI_SET_PA) begin
                    res.action = ACT_SET_PA;
                end else if (tp == TPCI_BCAST_READ && ap == APCI_READ) begin
                    res.action = ACT_READ_PA;
                    res.reply = RPL_ACK;
                end
            end
        end else if (!r.group_flag) begin
            if (r.dest_address == own_addr_cfg) begin
                case (tp)
                    TPCI_NDP: begin
                        if ((ap & APCI_CLASS_MASK) == APCI_WRITE) begin
                            res.action = ACT_MEM_WRITE;
                            res.reply = RPL_ACK;
                            res.send_transport_ack = 1'b1;
                        end else if ((ap & APCI_CLASS_MASK) == APCI_READ) begin
                            res.action = ACT_MEM_READ;
                            res.reply = RPL_ACK;
                            res.send_transport_ack = 1'b1;
                            res.response_sequence = packet_count;
                            packet_count = packet_count + 4'd1;
                        end
                    end
                    TPCI_NDP_CTRL: begin
                        if (ap == APCI_RESTART) begin
                            res.action = ACT_RESTART;
                            prog_cfg = 1'b0;
                            transparent_cfg = 1'b0;
                            link_up = 1'b0;
                            packet_count = SEQ_START;
                        end else if (ap == APCI_READ) begin
                            res.action = ACT_READ_MASK;
                            res.reply = RPL_ACK;
                            res.send_transport_ack = 1'b1;
                        end
                    end
                    TPCI_CONNECT: begin
                        if (!link_up) begin
                            res.action = ACT_CONNECT;
                            res.reply = RPL_ACK;
                            link_up = 1'b1;
                            partner_addr = r.source_address;
                            packet_count = SEQ_START;
                        end
                    end
                    TPCI_DISCONNECT: begin
                        if (link_up && partner_addr == r.source_address) begin
                            res.action = ACT_DISCONNECT;
                            link_up = 1'b0;
                            packet_count = SEQ_START;
                        end
                    end
                    TPCI_ACK, TPCI_NAK: begin
                        res.action = ACT_PEER_ACK;
                        res.reply = RPL_ACK;
                    end
                    default: ;
                endcase
            end
        end else begin
            if (tp == TPCI_UDP) begin
                if ((ap & APCI_CLASS_MASK) == APCI_WRITE) res.action = ACT_GROUP_WRITE;
                else if (ap == APCI_READ) res.action = ACT_GROUP_READ;
            end
        end
        res.link_connected = link_up;
        res.peer_address   = partner_addr;
        return res;
    endfunction

    function automatic t_req random_telegram();
        int unsigned pick;
        logic [7:0]  seq_bits;
        logic [15:0] src;
        pick = $urandom_range(0, 99);
        seq_bits = 8'($urandom) & ~TPCI_MASK;
        src = 16'($urandom);
        if (pick < 8) begin
            return telegram(1'($urandom), 5'($urandom), src, 16'($urandom), 1'($urandom),
                            8'($urandom), 8'($urandom));
        end else if (pick < 14) begin
            return telegram(1'b0, 5'($urandom), src, 16'($urandom), 1'($urandom),
                            8'($urandom), 8'($urandom));
        end else if (pick < 20) begin
            case ($urandom_range(0, 2))
                0: return telegram(1'b1, 5'($urandom), src, 16'h0000, 1'($urandom),
                                   seq_bits | TPCI_UDP, APCI_SET_PA);
                1: return telegram(1'b1, 5'($urandom), src, 16'h0000, 1'($urandom),
                                   seq_bits | TPCI_BCAST_READ, APCI_READ);
                default: return telegram(1'b1, 5'($urandom), src, 16'h0000, 1'($urandom),
                                         8'($urandom), 8'($urandom));
            endcase
        end else if (pick < 22) begin
            if ($urandom_range(0, 3) == 0) src = partner_addr;
            return telegram(1'b1, 5'($urandom), src, own_addr_cfg, 1'b0,
                            seq_bits | TPCI_CONNECT, 8'($urandom));
        end else if (pick < 24) begin
            if ($urandom_range(0, 3) != 0) src = partner_addr;
            return telegram(1'b1, 5'($urandom), src, own_addr_cfg, 1'b0,
                            seq_bits | TPCI_DISCONNECT, 8'($urandom));
        end else if (pick < 42) begin
            return telegram(1'b1, 5'($urandom), src, own_addr_cfg, 1'b0, seq_bits | TPCI_NDP,
                            (8'($urandom) & ~APCI_CLASS_MASK) | APCI_WRITE);
        end else if (pick < 72) begin
            return telegram(1'b1, 5'($urandom), src, own_addr_cfg, 1'b0, seq_bits | TPCI_NDP,
                            (8'($urandom) & ~APCI_CLASS_MASK) | APCI_READ);
        end else if (pick < 78) begin
            return telegram(1'b1, 5'($urandom), src, own_addr_cfg, 1'b0,
                            seq_bits | TPCI_NDP_CTRL, APCI_READ);
        end else if (pick < 79) begin
            return telegram(1'b1, 5'($urandom), src, own_addr_cfg, 1'b0,
                            seq_bits | TPCI_NDP_CTRL, APCI_RESTART);
        end else if (pick < 85) begin
            return telegram(1'b1, 5'($urandom), src, own_addr_cfg, 1'b0,
                            seq_bits | ($urandom_range(0, 1) ? TPCI_ACK : TPCI_NAK),
                            8'($urandom));
        end else if (pick < 90) begin
            return telegram(1'b1, 5'($urandom), src, own_addr_cfg, 1'b0, 8'($urandom),
                            8'($urandom));
        end else if (pick < 94) begin
            return telegram(1'b1, 5'($urandom), src, 16'($urandom), 1'b0, 8'($urandom),
                            8'($urandom));
        end else begin
            case ($urandom_range(0, 2))
                0: return telegram(1'b1, 5'($urandom), src, 16'($urandom), 1'b1,
                                   seq_bits | TPCI_UDP,
                                   (8'($urandom) & ~APCI_CLASS_MASK) | APCI_WRITE);
                1: return telegram(1'b1, 5'($urandom), src, 16'($urandom), 1'b1,
                                   seq_bits | TPCI_UDP, APCI_READ);
                default: return telegram(1'b1, 5'($urandom), src, 16'($urandom), 1'b1,
                                         8'($urandom), 8'($urandom));
            endcase
        end
    endfunction

    task automatic send_telegram(input t_req req);
        int unsigned gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.item  <= req;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        expected_dispatch.push_back(predict_dispatch(req));
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_dispatch.size() != 0);
    endtask

    task automatic settle();
        wait_drained();
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input t_reg_idx idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_OWN_ADDR:    own_addr_cfg = data[15:0];
            REG_PROG_MODE:   prog_cfg = data[0];
            REG_TRANSPARENT: transparent_cfg = data[0];
            default: ;
        endcase
    endtask

    task automatic test_bad_checksum();
        send_telegram(telegram(1'b0, 5'd0, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF, 8'hFF));
        send_telegram(telegram(1'b0, 5'd1, 16'h0000, 16'h0000, 1'b0, 8'h00, 8'h00));
        send_telegram(telegram(1'b0, 5'd2, 16'h1234, 16'h0000, 1'b0, TPCI_CONNECT, 8'h00));
        send_telegram(telegram(1'b0, 5'd31, 16'hFFFF, 16'hFFFF, 1'b0, 8'hAA, 8'h55));
    endtask

    task automatic test_broadcast();
        send_telegram(telegram(1'b1, 5'd8, 16'h1101, 16'h0000, 1'b0, TPCI_UDP, APCI_SET_PA));
        settle();
        write_register(REG_PROG_MODE, 32'hFFFF_FFFF);
        send_telegram(telegram(1'b1, 5'd8, 16'h1101, 16'h0000, 1'b1, TPCI_UDP, APCI_SET_PA));
        send_telegram(telegram(1'b1, 5'd7, 16'h1101, 16'h0000, 1'b0, TPCI_BCAST_READ,
                               APCI_READ));
        send_telegram(telegram(1'b1, 5'd7, 16'h1101, 16'h0000, 1'b0, TPCI_NDP, APCI_READ));
    endtask

    task automatic test_unicast();
        settle();
        write_register(REG_OWN_ADDR, 32'h5A5A_FFFF);
        send_telegram(telegram(1'b1, 5'd7, 16'h1234, 16'hFFFF, 1'b0, TPCI_DISCONNECT, 8'h00));
        send_telegram(telegram(1'b1, 5'd7, 16'h1234, 16'hFFFF, 1'b0, TPCI_CONNECT | 8'h3C,
                               8'h00));
        send_telegram(telegram(1'b1, 5'd7, 16'h5678, 16'hFFFF, 1'b0, TPCI_CONNECT, 8'h00));
        send_telegram(telegram(1'b1, 5'd12, 16'h1234, 16'hFFFF, 1'b0, TPCI_NDP | 8'h04,
                               APCI_WRITE | 8'h3F));
        send_telegram(telegram(1'b1, 5'd9, 16'h1234, 16'hFFFF, 1'b0, TPCI_NDP | 8'h38, 8'h3F));
        send_telegram(telegram(1'b1, 5'd9, 16'h1234, 16'hFFFF, 1'b0, TPCI_NDP, 8'h40));
        send_telegram(telegram(1'b1, 5'd8, 16'h1234, 16'hFFFF, 1'b0, TPCI_NDP_CTRL, APCI_READ));
        send_telegram(telegram(1'b1, 5'd7, 16'h1234, 16'hFFFF, 1'b0, TPCI_ACK, 8'h00));
        send_telegram(telegram(1'b1, 5'd7, 16'h1234, 16'hFFFF, 1'b0, TPCI_NAK | 8'h3C, 8'h00));
        send_telegram(telegram(1'b1, 5'd8, 16'h1234, 16'hFFFF, 1'b0, TPCI_UDP, APCI_READ));
        send_telegram(telegram(1'b1, 5'd12, 16'h1234, 16'hFFFE, 1'b0, TPCI_NDP, APCI_WRITE));
        send_telegram(telegram(1'b1, 5'd7, 16'h5678, 16'hFFFF, 1'b0, TPCI_DISCONNECT, 8'h00));
        send_telegram(telegram(1'b1, 5'd7, 16'h1234, 16'hFFFF, 1'b0, TPCI_DISCONNECT, 8'h00));
        send_telegram(telegram(1'b1, 5'd7, 16'hABCD, 16'hFFFF, 1'b0, TPCI_CONNECT, 8'h00));
        send_telegram(telegram(1'b1, 5'd8, 16'hABCD, 16'hFFFF, 1'b0, TPCI_NDP_CTRL,
                               APCI_RESTART));
    endtask

    task automatic test_group();
        send_telegram(telegram(1'b1, 5'd9, 16'h1101, 16'h0801, 1'b1, TPCI_UDP,
                               APCI_WRITE | 8'h01));
        send_telegram(telegram(1'b1, 5'd8, 16'h1101, 16'hFFFF, 1'b1, TPCI_UDP, APCI_READ));
        send_telegram(telegram(1'b1, 5'd8, 16'h1101, 16'h0801, 1'b1, TPCI_NDP, APCI_WRITE));
    endtask

    task automatic test_transparent();
        settle();
        write_register(REG_TRANSPARENT, 32'h0000_0001);
        send_telegram(telegram(1'b1, 5'd31, 16'h1101, 16'hFFFF, 1'b0, TPCI_CONNECT, 8'h00));
        send_telegram(telegram(1'b0, 5'd0, 16'h1101, 16'hFFFF, 1'b0, TPCI_CONNECT, 8'h00));
        settle();
        write_register(REG_TRANSPARENT, 32'h0000_0000);
    endtask

    task automatic test_backpressure();
        logic [7:0] seq_bits;
        settle();
        write_register(REG_OWN_ADDR, 32'($urandom_range(1, 16'hFFFF)));
        write_register(REG_PROG_MODE, 32'h0);
        write_register(REG_TRANSPARENT, 32'h0);
        send_gap_max = 0;
        receiver_hold = 150;
        repeat (20) begin
            seq_bits = 8'($urandom) & ~TPCI_MASK;
            send_telegram(telegram(1'b1, 5'($urandom), 16'($urandom), own_addr_cfg, 1'b0,
                                   seq_bits | TPCI_NDP,
                                   (8'($urandom) & ~APCI_CLASS_MASK) | APCI_READ));
        end
        wait_drained();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 8; phase++) begin
            settle();
            case (phase)
                1: write_register(REG_OWN_ADDR, {16'($urandom), 16'h0000});
                2: write_register(REG_OWN_ADDR, {16'($urandom), 16'hFFFF});
                default: write_register(REG_OWN_ADDR, $urandom);
            endcase
            write_register(REG_PROG_MODE, {31'($urandom), 1'(phase % 2)});
            write_register(REG_TRANSPARENT, {31'($urandom), 1'(phase == 3 || phase == 6)});
            if (phase == 0) begin
                send_gap_max = 0;
                recv_stall_max = 0;
            end else begin
                send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 19);
                recv_stall_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 19);
            end
            repeat (125) send_telegram(random_telegram());
        end
    endtask

    always @(posedge i_clk) begin : check_result
        t_rsp want;
        t_rsp got;
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got = rsp_if.item;
            if (expected_dispatch.size() == 0) begin
                mismatch_count++;
                if (reported_count < 10) begin
                    reported_count++;
                    $display("Unexpected result: action %0d reply %0d", got.action, got.reply);
                end
            end else begin
                want = expected_dispatch.pop_front();
                if (got.action !== want.action || got.reply !== want.reply ||
                    got.send_transport_ack !== want.send_transport_ack ||
                    got.response_sequence !== want.response_sequence ||
                    got.link_connected !== want.link_connected ||
                    got.peer_address !== want.peer_address) begin
                    mismatch_count++;
                    if (reported_count < 10) begin
                        reported_count++;
                        $display("Mismatch exp act %0d rpl %0d tack %0d seq %0d conn %0d peer %h",
                                 want.action, want.reply, want.send_transport_ack,
                                 want.response_sequence, want.link_connected, want.peer_address);
                        $display("         got act %0d rpl %0d tack %0d seq %0d conn %0d peer %h",
                                 got.action, got.reply, got.send_transport_ack,
                                 got.response_sequence, got.link_connected, got.peer_address);
                    end
                end
            end
        end
    end

    initial begin : receiver
        int unsigned stall;
        rsp_if.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = $urandom_range(0, recv_stall_max);
            if (receiver_hold > 0) begin
                stall = stall + receiver_hold;
                receiver_hold = 0;
            end
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_if.valid !== 1'b1);
        end
    end

    initial begin
        own_addr_cfg    = 16'h0000;
        prog_cfg        = 1'b0;
        transparent_cfg = 1'b0;
        link_up         = 1'b0;
        partner_addr    = 16'h0000;
        packet_count    = SEQ_START;
        mismatch_count  = 0;
        reported_count  = 0;
        send_gap_max    = 19;
        recv_stall_max  = 19;
        receiver_hold   = 0;
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.item  <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_bad_checksum();
        test_broadcast();
        test_unicast();
        test_group();
        test_transparent();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_dispatch.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
